// File: rtl/core/fcba_pkg.sv
`default_nettype none

package fcba_pkg;

  localparam int unsigned NumBlocksDef = 4096;
  localparam int unsigned BlockIdxW    = 12;
  localparam int unsigned BlockCntW    = 13;

  typedef enum logic [1:0] {
    REQ_ALLOC  = 2'd0,
    REQ_FREE   = 2'd1,
    REQ_NEXT   = 2'd2,
    REQ_FORMAT = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOSPACE  = 2'd1,
    ST_BADBLOCK = 2'd2
  } status_e;

  typedef struct packed {
    req_e                 req_type;
    logic [BlockIdxW-1:0] block_index;
    logic [BlockCntW-1:0] block_count;
  } in_t;

  typedef struct packed {
    logic [BlockIdxW-1:0] result_block;
    logic                 end_of_chain;
    status_e              status;
  } out_t;

endpackage

`default_nettype wire

// File: rtl/core/fcba_table.sv
`default_nettype none

module fcba_table #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned Width = 13
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// File: rtl/core/fcba_ctrl.sv
`default_nettype none

module fcba_ctrl
  import fcba_pkg::*;
#(
  parameter int unsigned NUM_BLOCKS = NumBlocksDef
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire in_t                                 req_i,
  output logic                                     idle_o,
  output logic                                     done_o,
  output out_t                                     res_o,
  output logic                                     we_o,
  output logic [$clog2(NUM_BLOCKS)-1:0]            waddr_o,
  output logic [$clog2(NUM_BLOCKS+1)-1:0]          wdata_o,
  output logic [$clog2(NUM_BLOCKS)-1:0]            raddr_o,
  input  wire logic [$clog2(NUM_BLOCKS+1)-1:0]     rdata_i
);

  localparam int unsigned AW = $clog2(NUM_BLOCKS);
  localparam int unsigned EW = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned CW = (EW > BlockCntW) ? EW : BlockCntW;

  localparam logic [AW:0]   NumAddr  = (AW+1)'(NUM_BLOCKS);
  localparam logic [AW-1:0] LastAddr = AW'(NUM_BLOCKS - 1);
  localparam logic [EW-1:0] EndMark  = EW'(NUM_BLOCKS);
  localparam logic [EW-1:0] FreeInit = EW'(NUM_BLOCKS - 1);

  typedef enum logic [5:0] {
    S_CLEAR     = 6'b000001,
    S_IDLE      = 6'b000010,
    S_ALLOC     = 6'b000100,
    S_ALLOC_END = 6'b001000,
    S_FREE      = 6'b010000,
    S_NEXT      = 6'b100000
  } state_e;

  state_e        state_q, state_d;
  logic [AW:0]   scan_q, scan_d;
  logic          chk_vld_q, chk_vld_d;
  logic [AW-1:0] chk_addr_q, chk_addr_d;
  logic [CW-1:0] taken_q, taken_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] walked_q, walked_d;
  logic [AW-1:0] first_q, first_d;
  logic [AW-1:0] prev_q, prev_d;
  logic [AW-1:0] cur_q, cur_d;
  logic          head_q, head_d;
  logic [EW-1:0] free_q, free_d;
  logic [AW-1:0] clr_q, clr_d;
  logic          fmt_q, fmt_d;

  logic          idx_bad;
  logic [CW-1:0] req_cnt;
  logic          found;
  logic [AW-1:0] nxt;

  assign idx_bad = (req_i.block_index == '0) ||
                   ({20'd0, req_i.block_index} >= 32'(NUM_BLOCKS));
  assign req_cnt = CW'(req_i.block_count);
  assign found   = chk_vld_q && (rdata_i == '0);
  assign nxt     = rdata_i[AW-1:0];
  assign idle_o  = (state_q == S_IDLE);

  always_comb begin
    state_d    = state_q;
    scan_d     = scan_q;
    chk_vld_d  = chk_vld_q;
    chk_addr_d = chk_addr_q;
    taken_d    = taken_q;
    cnt_d      = cnt_q;
    walked_d   = walked_q;
    first_d    = first_q;
    prev_d     = prev_q;
    cur_d      = cur_q;
    head_d     = head_q;
    free_d     = free_q;
    clr_d      = clr_q;
    fmt_d      = fmt_q;
    done_o     = 1'b0;
    res_o      = '0;
    res_o.status = ST_OK;
    we_o       = 1'b0;
    waddr_o    = cur_q;
    wdata_o    = '0;
    raddr_o    = cur_q;

    case (state_q)
      S_CLEAR: begin
        // sweep the whole table; entry 0 keeps the end mark
        we_o    = 1'b1;
        waddr_o = clr_q;
        wdata_o = (clr_q == '0) ? EndMark : '0;
        clr_d   = clr_q + AW'(1);
        if (clr_q == LastAddr) begin
          free_d  = FreeInit;
          done_o  = fmt_q;
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start_i) begin
          cnt_d = req_cnt;
          case (req_i.req_type)
            REQ_ALLOC: begin
              if (req_cnt == '0) begin
                done_o = 1'b1;
              end else if (req_cnt > CW'(free_q)) begin
                done_o       = 1'b1;
                res_o.status = ST_NOSPACE;
              end else begin
                scan_d    = (AW+1)'(1);
                chk_vld_d = 1'b0;
                taken_d   = '0;
                first_d   = '0;
                prev_d    = '0;
                state_d   = S_ALLOC;
              end
            end
            REQ_FREE, REQ_NEXT: begin
              if (idx_bad) begin
                done_o       = 1'b1;
                res_o.status = ST_BADBLOCK;
              end else begin
                cur_d    = AW'(req_i.block_index);
                raddr_o  = AW'(req_i.block_index);
                walked_d = '0;
                head_d   = 1'b1;
                state_d  = (req_i.req_type == REQ_FREE) ? S_FREE : S_NEXT;
              end
            end
            REQ_FORMAT: begin
              clr_d   = '0;
              fmt_d   = 1'b1;
              state_d = S_CLEAR;
            end
            default: begin
              done_o = 1'b1;
            end
          endcase
        end
      end

      S_ALLOC: begin
        // one read per cycle; the data seen now belongs to chk_addr_q
        raddr_o    = scan_q[AW-1:0];
        chk_addr_d = scan_q[AW-1:0];
        chk_vld_d  = (scan_q < NumAddr);
        if (scan_q < NumAddr) begin
          scan_d = scan_q + (AW+1)'(1);
        end
        if (found) begin
          if (taken_q != '0) begin
            we_o    = 1'b1;
            waddr_o = prev_q;
            wdata_o = EW'(chk_addr_q);
          end else begin
            first_d = chk_addr_q;
          end
          prev_d  = chk_addr_q;
          taken_d = taken_q + CW'(1);
        end
        if ((found && (taken_q + CW'(1) == cnt_q)) ||
            (chk_vld_q && (chk_addr_q == LastAddr)) ||
            (!chk_vld_q && (scan_q == NumAddr))) begin
          state_d = S_ALLOC_END;
        end
      end

      S_ALLOC_END: begin
        // close the chain on its last block
        we_o    = 1'b1;
        waddr_o = prev_q;
        wdata_o = EndMark;
        free_d  = free_q - EW'(taken_q);
        done_o  = 1'b1;
        res_o.result_block = BlockIdxW'(first_q);
        state_d = S_IDLE;
      end

      S_FREE: begin
        if (rdata_i == '0) begin
          // a free head is a bad request; a free link just ends the walk
          done_o       = 1'b1;
          res_o.status = head_q ? ST_BADBLOCK : ST_OK;
          state_d      = S_IDLE;
        end else if (walked_q == cnt_q) begin
          done_o  = 1'b1;
          state_d = S_IDLE;
        end else begin
          we_o     = 1'b1;
          waddr_o  = cur_q;
          wdata_o  = '0;
          free_d   = free_q + EW'(1);
          walked_d = walked_q + CW'(1);
          head_d   = 1'b0;
          if ((walked_q + CW'(1) == cnt_q) || (rdata_i == EndMark) || (nxt == cur_q)) begin
            done_o  = 1'b1;
            state_d = S_IDLE;
          end else begin
            cur_d   = nxt;
            raddr_o = nxt;
          end
        end
      end

      S_NEXT: begin
        done_o  = 1'b1;
        state_d = S_IDLE;
        if (rdata_i == '0) begin
          res_o.status = ST_BADBLOCK;
        end else if (rdata_i == EndMark) begin
          res_o.end_of_chain = 1'b1;
        end else begin
          res_o.result_block = BlockIdxW'(rdata_i);
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      scan_q     <= '0;
      chk_vld_q  <= 1'b0;
      chk_addr_q <= '0;
      taken_q    <= '0;
      cnt_q      <= '0;
      walked_q   <= '0;
      first_q    <= '0;
      prev_q     <= '0;
      cur_q      <= '0;
      head_q     <= 1'b0;
      free_q     <= FreeInit;
      clr_q      <= '0;
      fmt_q      <= 1'b0;
    end else begin
      state_q    <= state_d;
      scan_q     <= scan_d;
      chk_vld_q  <= chk_vld_d;
      chk_addr_q <= chk_addr_d;
      taken_q    <= taken_d;
      cnt_q      <= cnt_d;
      walked_q   <= walked_d;
      first_q    <= first_d;
      prev_q     <= prev_d;
      cur_q      <= cur_d;
      head_q     <= head_d;
      free_q     <= free_d;
      clr_q      <= clr_d;
      fmt_q      <= fmt_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/fat_chain_block_allocator.sv
`default_nettype none
// Channel | Direction | Handshake                  | Word
// in      | input     | in_valid_i / in_ready_o    | in_data_i  (req_type, block_index, block_count)
// out     | output    | out_valid_o / out_ready_i  | out_data_o (result_block, end_of_chain, status)
//
// Allocate scans the table one entry per cycle from block 1 until the requested
// blocks are found or the last entry is checked; free walks the chain one link
// per cycle; next reads the link that follows the given block; format sweeps
// the whole table. Rejected requests answer at once.
// After reset the whole table is swept clear before the first word is taken.
// A held result blocks the next word until it is taken.

module fat_chain_block_allocator
  import fcba_pkg::*;
#(
  parameter int unsigned NUM_BLOCKS = NumBlocksDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_data_o
);

  localparam int unsigned AW = $clog2(NUM_BLOCKS);
  localparam int unsigned EW = $clog2(NUM_BLOCKS + 1);

  logic          idle;
  logic          start;
  logic          done;
  out_t          res;
  logic          we;
  logic [AW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic [AW-1:0] raddr;
  logic [EW-1:0] rdata;
  logic          out_valid_q;
  out_t          out_data_q;

  assign in_ready_o  = idle && (!out_valid_q || out_ready_i);
  assign start       = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  fcba_ctrl #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .req_i  (in_data_i),
    .idle_o (idle),
    .done_o (done),
    .res_o  (res),
    .we_o   (we),
    .waddr_o(waddr),
    .wdata_o(wdata),
    .raddr_o(raddr),
    .rdata_i(rdata)
  );

  fcba_table #(
    .Depth(NUM_BLOCKS),
    .Width(EW)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // the slot is empty or being taken when a result completes: a word only enters when it is free or being taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_data_q <= res;
    end
  end

endmodule

`default_nettype wire
